@@ sv/sliding_window_loss_detector_defines.svh @@
// ----------------------------------------------------------------------------
// Sliding window loss detector: assertion macros
// Shared concurrent checks, clocked on clk with asynchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_LOSS_DETECTOR_DEFINES_SVH
`define SLIDING_WINDOW_LOSS_DETECTOR_DEFINES_SVH

// Same-cycle implication.
`define SWLD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SWLD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/swld_pkg.sv @@
// ----------------------------------------------------------------------------
// swld_pkg
// Types and constants shared by the sliding window loss detector.
// ----------------------------------------------------------------------------
package swld_pkg;

	localparam int WINDOW    = 64;
	localparam int CNT_W     = $clog2(WINDOW + 1);
	localparam int OUT_CNT_W = 7;
	localparam int THR_W     = 17;
	localparam int FRAC_W    = 16;
	localparam int PROD_W    = THR_W + CNT_W;

	localparam logic [THR_W-1:0] ONE_Q16   = THR_W'(1 << FRAC_W);
	localparam logic [CNT_W-1:0] WINDOW_CT = CNT_W'(WINDOW);

	typedef enum logic {
		OP_RECORD = 1'b0,
		OP_CLEAR  = 1'b1
	} swld_op_t;

	typedef struct packed {
		swld_op_t opcode;
		logic     packet_lost;
	} swld_in_t;

	typedef struct packed {
		logic                 congested;
		logic [OUT_CNT_W-1:0] lost_in_window;
		logic [OUT_CNT_W-1:0] entries_in_window;
	} swld_out_t;

	// Per-beat control from the top level to the statistics unit
	typedef struct packed {
		logic rec;       // record beat accepted
		logic clr;       // clear beat accepted
		logic lost_bit;  // outcome being recorded
		logic evict_bit; // oldest outcome at the tail of the cell chain
	} swld_ctl_t;

endpackage

@@ sv/swld_cell.sv @@
// ----------------------------------------------------------------------------
// swld_cell
// One outcome slot of the window; advances its bit to the next cell on shift.
// ----------------------------------------------------------------------------
module swld_cell (
	input  logic clk,
	input  logic shift,
	input  logic bit_in,
	output logic bit_out
);

	logic outcome_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			outcome_q <= bit_in;
		end
	end

	assign bit_out = outcome_q;

endmodule

@@ sv/swld_stats.sv @@
// ----------------------------------------------------------------------------
// swld_stats
// Fill and loss counters plus the threshold compare for each beat.
// ----------------------------------------------------------------------------
`include "sliding_window_loss_detector_defines.svh"

module swld_stats (
	input  logic                      clk,
	input  logic                      arst_n,
	input  swld_pkg::swld_ctl_t       ctl,
	input  logic [swld_pkg::THR_W-1:0] threshold,
	output swld_pkg::swld_out_t       rslt
);

	logic [swld_pkg::CNT_W-1:0]  filled_q;
	logic [swld_pkg::CNT_W-1:0]  lost_q;
	logic [swld_pkg::CNT_W-1:0]  filled_nxt;
	logic [swld_pkg::CNT_W-1:0]  lost_nxt;
	logic                        full;
	logic [swld_pkg::THR_W-1:0]  thr_eff;
	logic [swld_pkg::PROD_W-1:0] lhs;
	logic [swld_pkg::PROD_W-1:0] rhs;

	assign full = (filled_q == swld_pkg::WINDOW_CT);

	// Drop the evicted outcome, then add the new one
	assign lost_nxt   = lost_q - swld_pkg::CNT_W'(full & ctl.evict_bit)
	                  + swld_pkg::CNT_W'(ctl.lost_bit);
	assign filled_nxt = full ? filled_q : filled_q + swld_pkg::CNT_W'(1);

	// Anything at or above one never trips
	assign thr_eff = (threshold > swld_pkg::ONE_Q16) ? swld_pkg::ONE_Q16 : threshold;
	assign lhs     = swld_pkg::PROD_W'({lost_nxt, swld_pkg::FRAC_W'(0)});
	assign rhs     = swld_pkg::PROD_W'(thr_eff) * swld_pkg::PROD_W'(filled_nxt);

	always_comb begin
		if (ctl.clr) begin
			rslt = '0;
		end else begin
			rslt.congested         = (lhs > rhs);
			rslt.lost_in_window    = swld_pkg::OUT_CNT_W'(lost_nxt);
			rslt.entries_in_window = swld_pkg::OUT_CNT_W'(filled_nxt);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q <= '0;
			lost_q   <= '0;
		end else if (ctl.clr) begin
			filled_q <= '0;
			lost_q   <= '0;
		end else if (ctl.rec) begin
			filled_q <= filled_nxt;
			lost_q   <= lost_nxt;
		end
	end

	`SWLD_ASSERT_NOW(a_lost_le_filled, 1'b1, lost_q <= filled_q, "loss count above fill count")
	`SWLD_ASSERT_NOW(a_filled_le_window, 1'b1, filled_q <= swld_pkg::WINDOW_CT, "fill count above window")
	`SWLD_ASSERT_NXT(a_clear_empties, ctl.clr, filled_q == '0 && lost_q == '0, "clear left counts")

endmodule

@@ sv/sliding_window_loss_detector.sv @@
// ----------------------------------------------------------------------------
// sliding_window_loss_detector
// Tracks packet outcomes over a sliding window and flags congestion when the
// lost fraction is strictly above a programmable unsigned Q1.16 threshold.
// ----------------------------------------------------------------------------
//   channel | signals                         | dir | beat carries
//   --------+---------------------------------+-----+---------------------------
//   pkt     | pkt_valid pkt_ready pkt         | in  | opcode, packet_lost
//   res     | res_valid res_ready res         | out | congested, both counts
//   cfg     | cfg_valid cfg_ready cfg_data    | in  | loss_threshold (17 bits)
//
// One beat per cycle while pkt_ready is high: a pkt beat updates the counters
// and cell chain when accepted; its result goes to the main or skid register.
// The critical path is the 17 x 7 threshold multiply and the compare.
// A two-entry output buffer (main register plus skid) lets pkt keep flowing
// while a result waits; pkt_ready drops only when both entries are full.
// Reset clears counters, threshold (to 1.0) and the output buffer; the cell
// chain needs no clearing since the tail is read only when the window is full.
// ----------------------------------------------------------------------------
`include "sliding_window_loss_detector_defines.svh"

module sliding_window_loss_detector (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       pkt_valid,
	output logic                       pkt_ready,
	input  swld_pkg::swld_in_t         pkt,
	output logic                       res_valid,
	input  logic                       res_ready,
	output swld_pkg::swld_out_t        res,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [swld_pkg::THR_W-1:0] cfg_data
);

	logic                       pkt_fire;
	logic                       res_fire;
	logic [swld_pkg::THR_W-1:0] thr_q;
	swld_pkg::swld_ctl_t        ctl;
	swld_pkg::swld_out_t        rslt;
	swld_pkg::swld_out_t        main_q;
	swld_pkg::swld_out_t        skid_q;
	logic                       main_vld_q;
	logic                       skid_vld_q;
	logic [swld_pkg::WINDOW:0]  chain;

	assign cfg_ready = 1'b1;
	assign pkt_ready = !skid_vld_q;
	assign pkt_fire  = pkt_valid && pkt_ready;
	assign res_valid = main_vld_q;
	assign res       = main_q;
	assign res_fire  = main_vld_q && res_ready;

	// Threshold register; the user must write it only while idle, unenforced
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= swld_pkg::ONE_Q16;
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	assign ctl.rec       = pkt_fire && (pkt.opcode == swld_pkg::OP_RECORD);
	assign ctl.clr       = pkt_fire && (pkt.opcode == swld_pkg::OP_CLEAR);
	assign ctl.lost_bit  = pkt.packet_lost;
	assign ctl.evict_bit = chain[swld_pkg::WINDOW];

	// Cell chain: newest outcome enters at the head, oldest sits at the tail
	assign chain[0] = pkt.packet_lost;

	for (genvar i = 0; i < swld_pkg::WINDOW; i++) begin : g_cell
		swld_cell u_cell (
			.clk     (clk),
			.shift   (ctl.rec),
			.bit_in  (chain[i]),
			.bit_out (chain[i+1])
		);
	end

	swld_stats u_stats (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.threshold (thr_q),
		.rslt      (rslt)
	);

	// Output buffer: fill main when free, spill to skid when res stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (pkt_fire) begin
			if (!main_vld_q || res_fire) begin
				main_vld_q <= 1'b1;
			end else begin
				skid_vld_q <= 1'b1;
			end
		end else if (res_fire) begin
			main_vld_q <= skid_vld_q;
			skid_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt_fire) begin
			if (!main_vld_q || res_fire) begin
				main_q <= rslt;
			end else begin
				skid_q <= rslt;
			end
		end else if (res_fire && skid_vld_q) begin
			main_q <= skid_q;
		end
	end

	`SWLD_ASSERT_NOW(a_skid_needs_main, skid_vld_q, main_vld_q, "skid full with main empty")
	`SWLD_ASSERT_NXT(a_clear_result, ctl.clr && !main_vld_q, res_valid && !res.congested && res.entries_in_window == '0, "clear result not zero")
	`SWLD_ASSERT_NXT(a_no_loss_on_stall, skid_vld_q && !res_ready, skid_vld_q && main_vld_q, "buffered result dropped")

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb: sliding window loss detector testbench
// Drives packet outcome and clear beats through the pkt channel, programs the
// loss threshold between phases, and checks every result beat against an
// in-bench model of the window, its counts and the congestion compare.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// DUT ports; every input starts at a known value
	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       pkt_valid = 1'b0;
	logic                       pkt_ready;
	swld_pkg::swld_in_t         pkt       = '0;
	logic                       res_valid;
	logic                       res_ready = 1'b0;
	swld_pkg::swld_out_t        res;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [swld_pkg::THR_W-1:0] cfg_data  = '0;

	// Window model: outcome bits, head slot, fill level, loss count, flag, threshold
	logic [swld_pkg::WINDOW-1:0] win_bits      = '0;
	int unsigned                 win_head      = 0;
	int unsigned                 win_fill      = 0;
	int unsigned                 win_lost      = 0;
	logic                        win_congested = 1'b0;
	logic [swld_pkg::THR_W-1:0]  win_thr       = swld_pkg::ONE_Q16;

	// Predicted result beats, oldest first
	swld_pkg::swld_out_t pending_reports[$];

	// Bookkeeping
	int n_sent      = 0;  // pkt beats accepted, counted by the sender
	int n_reports   = 0;  // res beats seen
	int n_err       = 0;
	int n_records   = 0;
	int n_evictions = 0;
	int n_clears    = 0;
	int n_congested = 0;
	int n_cfg       = 0;
	int burst_left  = 1;

	// Receiver stall pattern state
	int stall_mode = 0;
	int stall_span = 0;
	int hold_cnt   = 0;

	sliding_window_loss_detector u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_valid (pkt_valid),
		.pkt_ready (pkt_ready),
		.pkt       (pkt),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// Advance the window model by one accepted beat and return the result
	// it should produce. A clear empties everything but the threshold; a
	// record evicts the oldest outcome first when the window is full, then
	// compares lost * 1.0 against threshold * fill without dividing.
	function automatic swld_pkg::swld_out_t track_loss(input swld_pkg::swld_in_t beat);
		swld_pkg::swld_out_t rpt;
		longint unsigned     lhs;
		longint unsigned     rhs;
		if (beat.opcode == swld_pkg::OP_CLEAR) begin
			win_head      = 0;
			win_fill      = 0;
			win_lost      = 0;
			win_congested = 1'b0;
		end else begin
			if (win_fill >= swld_pkg::WINDOW) begin
				if (win_bits[win_head] && win_lost > 0)
					win_lost--;
				win_fill = swld_pkg::WINDOW - 1;
			end
			win_bits[win_head] = beat.packet_lost;
			if (beat.packet_lost)
				win_lost++;
			win_head = (win_head + 1) % swld_pkg::WINDOW;
			win_fill++;
			lhs = 64'(win_lost) << swld_pkg::FRAC_W;
			rhs = 64'(win_thr) * 64'(win_fill);
			win_congested = lhs > rhs;
		end
		rpt.congested         = win_congested;
		rpt.lost_in_window    = swld_pkg::OUT_CNT_W'(win_lost);
		rpt.entries_in_window = swld_pkg::OUT_CNT_W'(win_fill);
		return rpt;
	endfunction

	// Scoreboard: check the result beat of this edge first, then fold in
	// any cfg or pkt beat taken at the same edge. One block keeps the
	// queue order free of races.
	always @(posedge clk) begin
		swld_pkg::swld_out_t want;
		if (arst_n) begin
			if (res_valid && res_ready) begin
				n_reports++;
				if (pending_reports.size() == 0) begin
					n_err++;
					if (n_err <= 10)
						$display("%0t: result beat with nothing pending: %0b/%0d/%0d",
							$realtime, res.congested, res.lost_in_window,
							res.entries_in_window);
				end else begin
					want = pending_reports.pop_front();
					if (res.congested != want.congested
							|| res.lost_in_window != want.lost_in_window
							|| res.entries_in_window != want.entries_in_window) begin
						n_err++;
						if (n_err <= 10)
							$display({"%0t: mismatch congested/lost/entries",
								" expected %0b/%0d/%0d got %0b/%0d/%0d"}, $realtime,
								want.congested, want.lost_in_window,
								want.entries_in_window, res.congested,
								res.lost_in_window, res.entries_in_window);
					end
					if (want.congested)
						n_congested++;
				end
			end
			if (cfg_valid && cfg_ready) begin
				win_thr = cfg_data;
				n_cfg++;
			end
			if (pkt_valid && pkt_ready) begin
				if (pkt.opcode == swld_pkg::OP_CLEAR)
					n_clears++;
				else begin
					n_records++;
					if (win_fill >= swld_pkg::WINDOW)
						n_evictions++;
				end
				pending_reports.push_back(track_loss(pkt));
			end
		end
	end

	// Receiver: draw a new stall pattern each time the span runs out, so that
	// back pressure lands on every phase, with spells of no stall at all.
	always @(posedge clk) begin
		if (stall_span == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_span <= $urandom_range(32, 200);
		end else begin
			stall_span <= stall_span - 1;
		end
		case (stall_mode)
			0: begin
				res_ready <= 1'b1;
			end
			1: begin
				res_ready <= 1'($urandom_range(0, 1));
			end
			2: begin
				// raise ready only when stall_span is a multiple of four
				res_ready <= (stall_span % 4 == 0);
			end
			default: begin
				// long alternating holds of ready and stall
				if (hold_cnt == 0) begin
					res_ready <= ~res_ready;
					hold_cnt  <= $urandom_range(1, 20);
				end else begin
					hold_cnt <= hold_cnt - 1;
				end
			end
		endcase
	end

	// Send one pkt beat and hold it until accepted. Valid stays high into
	// the next call unless the burst ends here and a gap is drawn.
	task automatic send_pkt(input swld_pkg::swld_op_t op, input logic lost);
		int gap;
		pkt       <= '{opcode: op, packet_lost: lost};
		pkt_valid <= 1'b1;
		@(posedge clk);
		while (!pkt_ready)
			@(posedge clk);
		n_sent++;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = $urandom_range(1, 40);
			if (gap > 0) begin
				pkt_valid <= 1'b0;
				repeat (gap)
					@(posedge clk);
			end
		end
	endtask

	// Drop valid and wait until every accepted beat has produced its result.
	task automatic wait_idle();
		pkt_valid <= 1'b0;
		while (n_reports < n_sent)
			@(posedge clk);
		repeat (3)
			@(posedge clk);
	endtask

	// Program the threshold; only called while the block is idle.
	task automatic write_threshold(input logic [swld_pkg::THR_W-1:0] value);
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Threshold at its reset value of 1.0: losses never congest; clears
	// ignore packet_lost, including a clear of an already empty window.
	task automatic test_reset_threshold();
		send_pkt(swld_pkg::OP_RECORD, 1'b1);
		send_pkt(swld_pkg::OP_RECORD, 1'b0);
		send_pkt(swld_pkg::OP_RECORD, 1'b1);
		send_pkt(swld_pkg::OP_RECORD, 1'b1);
		send_pkt(swld_pkg::OP_CLEAR, 1'b1);
		send_pkt(swld_pkg::OP_RECORD, 1'b1);
		send_pkt(swld_pkg::OP_CLEAR, 1'b0);
		send_pkt(swld_pkg::OP_CLEAR, 1'b1);
		send_pkt(swld_pkg::OP_RECORD, 1'b0);
		wait_idle();
	endtask

	// Threshold extremes: zero flags any loss, just below one flags only an
	// all-lost window, and values at or above one never flag.
	task automatic test_threshold_extremes();
		write_threshold('0);
		send_pkt(swld_pkg::OP_RECORD, 1'b0);
		send_pkt(swld_pkg::OP_RECORD, 1'b1);
		send_pkt(swld_pkg::OP_RECORD, 1'b0);
		send_pkt(swld_pkg::OP_CLEAR, 1'b0);
		send_pkt(swld_pkg::OP_RECORD, 1'b1);
		wait_idle();
		write_threshold(swld_pkg::ONE_Q16 - 1);
		send_pkt(swld_pkg::OP_CLEAR, 1'b1);
		send_pkt(swld_pkg::OP_RECORD, 1'b1);
		send_pkt(swld_pkg::OP_RECORD, 1'b1);
		send_pkt(swld_pkg::OP_RECORD, 1'b0);
		wait_idle();
		write_threshold('1);
		send_pkt(swld_pkg::OP_RECORD, 1'b1);
		send_pkt(swld_pkg::OP_RECORD, 1'b1);
		wait_idle();
	endtask

	// Half threshold over three full windows: received, then lost, then
	// received again. Eviction walks the loss count up and down through
	// the exact-half point, which must not congest.
	task automatic test_eviction_boundary();
		write_threshold(swld_pkg::ONE_Q16 >> 1);
		send_pkt(swld_pkg::OP_CLEAR, 1'b0);
		for (int i = 0; i < 3 * swld_pkg::WINDOW; i++)
			send_pkt(swld_pkg::OP_RECORD, (i / swld_pkg::WINDOW) == 1);
		wait_idle();
	endtask

	// Random phases, one per threshold. Loss rate hovers around the
	// threshold fraction so the flag keeps toggling; rare clears keep the
	// window mostly full and evicting.
	task automatic test_threshold_sweep();
		logic [swld_pkg::THR_W-1:0] thr_list[12];
		int base_pct;
		int pct;
		thr_list[0]  = '0;
		thr_list[1]  = swld_pkg::THR_W'(1);
		thr_list[2]  = swld_pkg::THR_W'(16384);
		thr_list[3]  = swld_pkg::THR_W'(32768);
		thr_list[4]  = swld_pkg::THR_W'(49152);
		thr_list[5]  = swld_pkg::ONE_Q16 - 1;
		thr_list[6]  = swld_pkg::ONE_Q16;
		thr_list[7]  = '1;
		thr_list[8]  = swld_pkg::THR_W'($urandom_range(0, 65536));
		thr_list[9]  = swld_pkg::THR_W'($urandom_range(0, 65536));
		thr_list[10] = swld_pkg::THR_W'($urandom_range(0, 65536));
		thr_list[11] = swld_pkg::THR_W'($urandom_range(65537, 131071));
		foreach (thr_list[p]) begin
			write_threshold(thr_list[p]);
			base_pct = (thr_list[p] >= swld_pkg::ONE_Q16) ? 100
			         : (int'(thr_list[p]) * 100) >> 16;
			pct      = base_pct;
			for (int i = 0; i < 140; i++) begin
				if (i % 24 == 0) begin
					pct = base_pct + int'($urandom_range(0, 40)) - 20;
					if (pct < 0)
						pct = 0;
					if (pct > 100)
						pct = 100;
				end
				if ($urandom_range(0, 69) == 0)
					send_pkt(swld_pkg::OP_CLEAR, 1'($urandom_range(0, 1)));
				else
					send_pkt(swld_pkg::OP_RECORD, $urandom_range(0, 99) < pct);
			end
			wait_idle();
		end
	endtask

	initial begin
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_threshold();
		test_threshold_extremes();
		test_eviction_boundary();
		test_threshold_sweep();

		$display("Covered %0d records (%0d evicting), %0d clears, %0d congested results.",
			n_records, n_evictions, n_clears, n_congested);
		$display("Used %0d threshold writes; checked %0d result beats, %0d errors.",
			n_cfg, n_reports, n_err);
		if (n_err == 0 && pending_reports.size() == 0 && n_reports == n_sent)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Hard stop: several times the slowest legal run
	initial begin
		#10ms;
		$display("Timed out with %0d results outstanding.", pending_reports.size());
		$display("TEST FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+sv
sv/swld_pkg.sv
sv/swld_cell.sv
sv/swld_stats.sv
sv/sliding_window_loss_detector.sv
dv/tb.sv
